FILE: design/dxt5_block_decoder_assert.svh
// Assertion macros for the DXT5 block decoder.
// Simulation builds get real checks; synthesis builds see empty macros.
`ifndef DXT5_BLOCK_DECODER_ASSERT_SVH
`define DXT5_BLOCK_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define DXT5_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dxt5 assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define DXT5_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dxt5 assertion failed");
`else
`define DXT5_ASSERT_NOW(label, ante, cons)
`define DXT5_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: design/dxt5_pkg.sv
// Shared types, constants and palette helpers for the DXT5 block decoder.
// No dependencies; imported by dxt5_cdiv, dxt5_block_decoder and the testbench.
`default_nettype none

package dxt5_pkg;

  typedef logic [3:0] texel_num_t;
  typedef logic [5:0] divisor_t;
  typedef logic [15:0] recip_t;

  localparam texel_num_t LastTexel = 4'd15;

  // Constant division is done as a reciprocal multiply followed by one
  // correction step. Each reciprocal is floor(2^RecipShift / divisor).
  localparam int RecipShift = 18;
  localparam recip_t Recip31 = 16'd8456;
  localparam recip_t Recip63 = 16'd4161;
  localparam recip_t Recip7  = 16'd37449;
  localparam recip_t Recip5  = 16'd52428;
  localparam divisor_t Div31 = 6'd31;
  localparam divisor_t Div63 = 6'd63;
  localparam divisor_t Div7  = 6'd7;
  localparam divisor_t Div5  = 6'd5;

  // The color palette is v*255/(3*M) with v in thirds; 255/3 = 85.
  localparam logic [6:0] ColorScale = 7'd85;
  localparam logic [10:0] AlphaOpaqueFifths = 11'd1275;

  typedef enum logic [1:0] {
    CSEL_END0,
    CSEL_END1,
    CSEL_MIX0,
    CSEL_MIX1
  } color_sel_t;

  typedef enum logic [2:0] {
    ASEL_END0,
    ASEL_END1,
    ASEL_MID2,
    ASEL_MID3,
    ASEL_MID4,
    ASEL_MID5,
    ASEL_MID6,
    ASEL_MID7
  } alpha_sel_t;

  // Texel after index lookup: palette numerators, not yet divided.
  typedef struct packed {
    texel_num_t  num;
    logic        last;
    logic [6:0]  num_b;
    logic [7:0]  num_g;
    logic [6:0]  num_r;
    logic [10:0] num_a;
    logic        fifths;
  } stage1_t;

  // Numerator of one channel in thirds of an endpoint step.
  function automatic logic [7:0] color_num(input logic [5:0] v0, input logic [5:0] v1,
                                           input color_sel_t sel);
    logic [7:0] w0;
    logic [7:0] w1;
    w0 = {2'b00, v0};
    w1 = {2'b00, v1};
    case (sel)
      CSEL_END0: color_num = w0 * 8'd3;
      CSEL_END1: color_num = w1 * 8'd3;
      CSEL_MIX0: color_num = (w0 << 1) + w1;
      CSEL_MIX1: color_num = w0 + (w1 << 1);
      default:   color_num = w0 * 8'd3;
    endcase
  endfunction

  // Alpha numerator; the divisor is 5 in fifths mode and 7 otherwise.
  // Endpoints are scaled by the divisor so that every case divides.
  function automatic logic [10:0] alpha_num(input logic [7:0] a0, input logic [7:0] a1,
                                            input alpha_sel_t sel, input logic fifths);
    logic [2:0] w0;
    logic [2:0] w1;
    logic [10:0] sum;
    w0 = 3'(4'd8 - {1'b0, sel});
    w1 = 3'(sel) - 3'd1;
    if (fifths) begin
      w0 = 3'(4'd6 - {1'b0, sel});
      case (sel)
        ASEL_END0: begin
          w0 = 3'd5;
          w1 = 3'd0;
        end
        ASEL_END1: begin
          w0 = 3'd0;
          w1 = 3'd5;
        end
        ASEL_MID6, ASEL_MID7: begin
          w0 = 3'd0;
          w1 = 3'd0;
        end
        default: ;
      endcase
    end else begin
      case (sel)
        ASEL_END0: begin
          w0 = 3'd7;
          w1 = 3'd0;
        end
        ASEL_END1: begin
          w0 = 3'd0;
          w1 = 3'd7;
        end
        default: ;
      endcase
    end
    sum = 11'(a0) * 11'(w0) + 11'(a1) * 11'(w1);
    if (fifths && sel == ASEL_MID7) begin
      sum = AlphaOpaqueFifths;
    end
    alpha_num = sum;
  endfunction

endpackage

`default_nettype wire

FILE: design/dxt5_block_if.sv
// Input channel carrying one compressed 128-bit DXT5 block per transaction.
// Standalone; no package dependency.
`default_nettype none

interface dxt5_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_word;
  logic [31:0] color_word;
  logic [31:0] index_word;

  modport source (output valid, output alpha_word, output color_word,
                  output index_word, input ready);
  modport sink (input valid, input alpha_word, input color_word,
                input index_word, output ready);
endinterface

`default_nettype wire

FILE: design/dxt5_texel_if.sv
// Output channel carrying one decoded texel per transaction.
// Standalone; no package dependency.
`default_nettype none

interface dxt5_texel_if;
  logic       valid;
  logic       ready;
  logic [3:0] texel_number;
  logic [7:0] blue_value;
  logic [7:0] green_value;
  logic [7:0] red_value;
  logic [7:0] alpha_value;
  logic       last_texel;

  modport source (output valid, output texel_number, output blue_value,
                  output green_value, output red_value, output alpha_value,
                  output last_texel, input ready);
  modport sink (input valid, input texel_number, input blue_value,
                input green_value, input red_value, input alpha_value,
                input last_texel, output ready);
endinterface

`default_nettype wire

FILE: design/dxt5_cdiv.sv
// Two-stage division of a narrow value by a small constant divisor.
// Uses the reciprocal constants and types of dxt5_pkg.
`default_nettype none

module dxt5_cdiv
  import dxt5_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [13:0] x,
  input  wire recip_t     recip,
  input  wire divisor_t   divisor,
  output logic [7:0]      q
);

  logic [29:0] prod;
  logic [7:0]  q_est;
  logic [7:0]  q_est_next;
  logic [13:0] x_hold;
  divisor_t    div_hold;
  logic [13:0] rem;
  logic [7:0]  q_next;

  // The truncated reciprocal never overestimates and is short by at most one.
  assign prod       = 30'(x) * 30'(recip);
  assign q_est_next = prod[RecipShift +: 8];

  always_ff @(posedge clk) begin
    if (en) begin
      q_est    <= q_est_next;
      x_hold   <= x;
      div_hold <= divisor;
    end
  end

  assign rem    = x_hold - 14'(q_est * 14'(div_hold));
  assign q_next = (rem >= 14'(div_hold)) ? q_est + 8'd1 : q_est;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/dxt5_block_decoder.sv
// DXT5 block decoder: one block in, sixteen texels out in raster order.
// A texel passes the stage-1, stage-2 and both divider registers before it is valid.
// Throughput: one texel per cycle while the output is not stalled, set by the
// texel issue counter; the next block is taken while the last texel issues.
// Reset (rst, synchronous) empties the issue stage and all pipeline valids.
`default_nettype none
`include "dxt5_block_decoder_assert.svh"

module dxt5_block_decoder
  import dxt5_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  dxt5_block_if.sink   blk,
  dxt5_texel_if.source texel
);

  logic        en;
  logic        busy;
  texel_num_t  cnt;
  logic        accept;
  logic        fire;
  logic [63:0] alpha_reg;
  logic [31:0] color_reg;
  logic [31:0] index_reg;
  logic [47:0] alpha_idx;
  color_sel_t  csel;
  alpha_sel_t  asel;
  logic        fifths;
  stage1_t     s1_next;
  stage1_t     s1;
  logic        v1;
  logic        v2;
  logic        v3;
  logic        v4;
  logic [13:0] x_b;
  logic [13:0] x_g;
  logic [13:0] x_r;
  logic [13:0] x_a;
  logic        fifths2;
  texel_num_t  num2;
  logic        last2;
  texel_num_t  num3;
  logic        last3;
  texel_num_t  num4;
  logic        last4;
  logic [7:0]  q_b;
  logic [7:0]  q_g;
  logic [7:0]  q_r;
  logic [7:0]  q_a;

  // The whole pipeline moves together; it stalls only on a held output.
  assign en        = !v4 || texel.ready;
  assign fire      = busy && en;
  assign blk.ready = !rst && (!busy || (en && cnt == LastTexel));
  assign accept    = blk.valid && blk.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (fire) begin
      cnt <= cnt + 4'd1;
      if (cnt == LastTexel) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alpha_reg <= blk.alpha_word;
      color_reg <= blk.color_word;
      index_reg <= blk.index_word;
    end
  end

  // Stage 1: index lookup and palette numerators.
  assign alpha_idx = alpha_reg[63:16];
  assign csel      = color_sel_t'(index_reg[{cnt, 1'b0} +: 2]);
  assign asel      = alpha_sel_t'(alpha_idx[6'(cnt) * 6'd3 +: 3]);
  assign fifths    = !(alpha_reg[7:0] > alpha_reg[15:8]);

  always_comb begin
    s1_next.num    = cnt;
    s1_next.last   = (cnt == LastTexel);
    s1_next.num_b  = 7'(color_num({1'b0, color_reg[15:11]}, {1'b0, color_reg[31:27]}, csel));
    s1_next.num_g  = color_num(color_reg[10:5], color_reg[26:21], csel);
    s1_next.num_r  = 7'(color_num({1'b0, color_reg[4:0]}, {1'b0, color_reg[20:16]}, csel));
    s1_next.num_a  = alpha_num(alpha_reg[7:0], alpha_reg[15:8], asel, fifths);
    s1_next.fifths = fifths;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: scale color numerators to the 8-bit range.
  always_ff @(posedge clk) begin
    if (en) begin
      x_b     <= 14'(s1.num_b) * 14'(ColorScale);
      x_g     <= 14'(s1.num_g) * 14'(ColorScale);
      x_r     <= 14'(s1.num_r) * 14'(ColorScale);
      x_a     <= 14'(s1.num_a);
      fifths2 <= s1.fifths;
      num2    <= s1.num;
      last2   <= s1.last;
    end
  end

  // Stages 3 and 4: constant division inside the divider instances.
  dxt5_cdiv u_div_b (.clk(clk), .en(en), .x(x_b), .recip(Recip31), .divisor(Div31),
                     .q(q_b));
  dxt5_cdiv u_div_g (.clk(clk), .en(en), .x(x_g), .recip(Recip63), .divisor(Div63),
                     .q(q_g));
  dxt5_cdiv u_div_r (.clk(clk), .en(en), .x(x_r), .recip(Recip31), .divisor(Div31),
                     .q(q_r));
  dxt5_cdiv u_div_a (.clk(clk), .en(en), .x(x_a),
                     .recip(fifths2 ? Recip5 : Recip7),
                     .divisor(fifths2 ? Div5 : Div7), .q(q_a));

  always_ff @(posedge clk) begin
    if (en) begin
      num3  <= num2;
      last3 <= last2;
      num4  <= num3;
      last4 <= last3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= fire;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign texel.valid        = v4;
  assign texel.texel_number = num4;
  assign texel.blue_value   = q_b;
  assign texel.green_value  = q_g;
  assign texel.red_value    = q_r;
  assign texel.alpha_value  = q_a;
  assign texel.last_texel   = last4;

  `DXT5_ASSERT_NOW(a_last_marks_final, v4, last4 == (num4 == LastTexel))
  `DXT5_ASSERT_NEXT(a_accept_restarts, blk.valid && blk.ready, busy && cnt == '0)
  `DXT5_ASSERT_NEXT(a_stall_holds_issue, busy && !en && !accept, busy && $stable(cnt))

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for dxt5_block_decoder: random and directed DXT5 blocks in,
// every decoded texel compared against an in-bench palette decoder.
// Depends on dxt5_pkg, dxt5_block_if, dxt5_texel_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_top;
  import dxt5_pkg::*;

  typedef struct {
    logic [63:0] alpha_word;
    logic [31:0] color_word;
    logic [31:0] index_word;
  } block_t;

  typedef struct packed {
    logic [3:0] number;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last;
  } texel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dxt5_block_if block_ch ();
  dxt5_texel_if texel_ch ();

  dxt5_block_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .blk   (block_ch.sink),
    .texel (texel_ch.source)
  );

  block_t pending_blocks[$];
  texel_t texel_expect[$];

  int unsigned mismatches = 0;
  int unsigned texels_checked = 0;
  int unsigned blocks_taken = 0;
  int unsigned sevenths_blocks = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Drive every input to a known value before the first edge.
  initial begin
    block_ch.valid = 1'b0;
    block_ch.alpha_word = '0;
    block_ch.color_word = '0;
    block_ch.index_word = '0;
    texel_ch.ready = 1'b0;
  end

  // Expand a 5- or 6-bit channel and blend in thirds, truncating.
  function automatic logic [7:0] widen_channel(input int unsigned v0, input int unsigned v1,
                                               input color_sel_t sel,
                                               input int unsigned full_scale);
    int unsigned thirds;
    case (sel)
      CSEL_END0: thirds = 3 * v0;
      CSEL_END1: thirds = 3 * v1;
      CSEL_MIX0: thirds = 2 * v0 + v1;
      default:   thirds = v0 + 2 * v1;
    endcase
    return 8'((thirds * 255) / (3 * full_scale));
  endfunction

  function automatic texel_t decode_texel(input block_t words, input int unsigned t);
    int unsigned a0;
    int unsigned a1;
    int unsigned palette[8];
    logic [15:0] e0;
    logic [15:0] e1;
    color_sel_t csel;
    alpha_sel_t asel;
    texel_t res;
    a0 = words.alpha_word[7:0];
    a1 = words.alpha_word[15:8];
    e0 = words.color_word[15:0];
    e1 = words.color_word[31:16];
    palette[0] = a0;
    palette[1] = a1;
    if (a0 > a1) begin
      for (int k = 2; k < 8; k++) palette[k] = ((8 - k) * a0 + (k - 1) * a1) / 7;
    end else begin
      for (int k = 2; k < 6; k++) palette[k] = ((6 - k) * a0 + (k - 1) * a1) / 5;
      palette[6] = 0;
      palette[7] = 255;
    end
    csel = color_sel_t'(words.index_word[2 * t +: 2]);
    asel = alpha_sel_t'(words.alpha_word[16 + 3 * t +: 3]);
    res.number = t[3:0];
    res.blue = widen_channel(e0[15:11], e1[15:11], csel, 31);
    res.green = widen_channel(e0[10:5], e1[10:5], csel, 63);
    res.red = widen_channel(e0[4:0], e1[4:0], csel, 31);
    res.alpha = 8'(palette[asel]);
    res.last = (t == 15);
    return res;
  endfunction

  // Alpha word whose indices walk through all eight selections, forward or reversed.
  function automatic logic [63:0] sweep_alpha(input logic [7:0] a0, input logic [7:0] a1,
                                              input bit reversed);
    logic [63:0] w;
    w = {48'd0, a1, a0};
    for (int t = 0; t < 16; t++) w[16 + 3 * t +: 3] = reversed ? 3'(7 - t % 8) : 3'(t % 8);
    return w;
  endfunction

  function automatic logic [15:0] pick_endpoint();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender: bursts of blocks separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    block_t nxt;
    if (rst) begin
      block_ch.valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!block_ch.valid || block_ch.ready) begin
      if (gap_left != 0) begin
        block_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_blocks.size() != 0) begin
        nxt = pending_blocks.pop_front();
        block_ch.alpha_word <= nxt.alpha_word;
        block_ch.color_word <= nxt.color_word;
        block_ch.index_word <= nxt.index_word;
        block_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        block_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs, so the decoder fills up and stalls its input.
  int unsigned hold_left;
  int unsigned hold_seen_blocks;
  int unsigned holds_done;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen_blocks <= 0;
      holds_done <= 0;
    end else begin
      if (block_ch.valid && block_ch.ready) hold_seen_blocks <= hold_seen_blocks + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (block_ch.valid && block_ch.ready &&
                   (hold_seen_blocks == 30 || hold_seen_blocks == 110)) begin
        hold_left <= 300;
        holds_done <= holds_done + 1;
      end
    end
  end

  // Receiver: switches among always-ready, random and alternating stall patterns.
  int unsigned recv_mode;
  int unsigned mode_left;
  logic recv_toggle;

  always @(posedge clk) begin
    if (rst) begin
      texel_ch.ready <= 1'b0;
      recv_mode <= 0;
      mode_left <= 0;
      recv_toggle <= 1'b0;
    end else begin
      recv_toggle <= ~recv_toggle;
      if (mode_left == 0) begin
        recv_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        texel_ch.ready <= 1'b0;
      end else begin
        case (recv_mode)
          0: texel_ch.ready <= 1'b1;
          1: texel_ch.ready <= 1'($urandom_range(0, 1));
          2: texel_ch.ready <= ($urandom_range(0, 3) == 0);
          default: texel_ch.ready <= recv_toggle;
        endcase
      end
    end
  end

  // Monitor: predicts on each accepted block, checks each accepted texel.
  always @(posedge clk) begin
    block_t words;
    texel_t seen;
    texel_t want;
    if (!rst) begin
      if (block_ch.valid && block_ch.ready) begin
        words.alpha_word = block_ch.alpha_word;
        words.color_word = block_ch.color_word;
        words.index_word = block_ch.index_word;
        for (int t = 0; t < 16; t++) texel_expect.push_back(decode_texel(words, t));
        blocks_taken++;
        if (words.alpha_word[7:0] > words.alpha_word[15:8]) sevenths_blocks++;
      end
      if (texel_ch.valid && texel_ch.ready) begin
        seen = {texel_ch.texel_number, texel_ch.blue_value, texel_ch.green_value,
                texel_ch.red_value, texel_ch.alpha_value, texel_ch.last_texel};
        if (texel_expect.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: texel transaction with no block outstanding: %p", seen);
          mismatches++;
        end else begin
          want = texel_expect.pop_front();
          texels_checked++;
          if (seen.number !== want.number || seen.blue !== want.blue ||
              seen.green !== want.green || seen.red !== want.red ||
              seen.alpha !== want.alpha || seen.last !== want.last) begin
            if (mismatches < 10)
              $display("ERROR: texel mismatch at %0t: expected %p, got %p", $realtime, want,
                       seen);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    block_t b;
    // Directed blocks: endpoint extremes, both alpha modes with every index,
    // every color index, and equal color endpoints.
    b = '{64'd0, 32'd0, 32'd0};
    pending_blocks.push_back(b);
    b = '{'1, '1, '1};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'hff, 8'h00, 0), 32'hffff_0000, 32'he4e4_e4e4};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'h00, 8'hff, 0), 32'h0000_ffff, 32'h1b1b_1b1b};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'h80, 8'h80, 1), 32'h8c71_8c71, 32'he4e4_e4e4};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'd200, 8'd10, 1), 32'h07e0_f81f, 32'h4e4e_4e4e};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'd10, 8'd200, 1), 32'hf81f_07e0, 32'hb1b1_b1b1};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'd1, 8'd0, 0), 32'h001f_0000, 32'h9c9c_9c9c};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'd0, 8'd1, 0), 32'h0000_001f, 32'h3636_3636};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'hff, 8'hfe, 1), 32'hffff_ffff, 32'he4e4_e4e4};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'hff, 8'hff, 0), 32'h0000_0000, 32'he4e4_e4e4};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'h00, 8'h00, 1), 32'h07e0_07e0, 32'hffff_ffff};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'h5a, 8'ha5, 0), 32'h1234_fedc, 32'h5555_5555};
    pending_blocks.push_back(b);
    b = '{sweep_alpha(8'ha5, 8'h5a, 0), 32'hfedc_1234, 32'haaaa_aaaa};
    pending_blocks.push_back(b);

    for (int n = 0; n < 156; n++) begin
      int unsigned lo;
      int unsigned hi;
      b.alpha_word = {$urandom, $urandom};
      b.color_word = $urandom;
      b.index_word = $urandom;
      case ($urandom_range(0, 3))
        1: begin
          lo = $urandom_range(0, 254);
          hi = $urandom_range(lo + 1, 255);
          b.alpha_word[15:0] = {8'(lo), 8'(hi)};
        end
        2: begin
          lo = $urandom_range(0, 255);
          hi = $urandom_range(lo, 255);
          b.alpha_word[15:0] = {8'(hi), 8'(lo)};
        end
        3: begin
          b.color_word[15:0] = pick_endpoint();
          b.color_word[31:16] = ($urandom_range(0, 3) == 0) ? b.color_word[15:0]
                                                             : pick_endpoint();
        end
        default: ;
      endcase
      pending_blocks.push_back(b);
    end

    @(negedge clk);
    while (rst || pending_blocks.size() != 0 || block_ch.valid || texel_expect.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Decoded %0d blocks (%0d seven-step alpha, %0d five-step), %0d texels checked.",
             blocks_taken, sevenths_blocks, blocks_taken - sevenths_blocks, texels_checked);
    $display("Receiver held off for long stretches %0d times; %0d mismatches.", holds_done,
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d texels still expected.", texel_expect.size());
    $display("status: fail");
    $finish;
  end

endmodule
